// ----- rtl/cpu8reu_pkg.sv -----
// ----------------------------------------------------------------------------
// cpu8reu_pkg
// Shared types, flag positions and helper functions for the 8-bit register
// execute unit.
// ----------------------------------------------------------------------------
package cpu8reu_pkg;

   localparam int unsigned FLAG_N = 7;
   localparam int unsigned FLAG_V = 6;
   localparam int unsigned FLAG_5 = 5;
   localparam int unsigned FLAG_B = 4;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_I = 2;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_C = 0;

   localparam logic [7:0] RESET_ACC    = 8'h00;
   localparam logic [7:0] RESET_INDEX  = 8'h00;
   localparam logic [7:0] RESET_SP     = 8'hFD;
   localparam logic [7:0] RESET_STATUS = 8'h24;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] s;
      logic [7:0] p;
   } regs_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] index_x;
      logic [7:0] index_y;
      logic [7:0] stack_pointer;
      logic [7:0] status;
      logic       branch_taken;
      logic       push_valid;
      logic [7:0] push_data;
      logic [8:0] stack_address;
      logic       unsupported;
   } result_type;

   function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r         = p;
      r[FLAG_N] = v[7];
      r[FLAG_Z] = (v == 8'h00);
      return r;
   endfunction

   function automatic logic [7:0] with_cmp(input logic [7:0] p, input logic [7:0] r,
                                           input logic [7:0] m);
      logic [7:0] q;
      q         = with_nz(p, r - m);
      q[FLAG_C] = (r >= m);
      return q;
   endfunction

endpackage

// ----- rtl/cpu8_register_execute_unit_top.sv -----
// ----------------------------------------------------------------------------
// cpu8_register_execute_unit_top
// Execute unit of an 8-bit processor core with its own A, X, Y, stack
// pointer and status registers.
// ----------------------------------------------------------------------------
// Each request beat carries one decoded instruction: the opcode and its
// operand byte (immediate, fetched memory value or pulled stack byte).
// Each request produces exactly one response beat holding the registers
// after the instruction, the branch condition, any stack push and the stack
// address used, and a flag for opcodes outside the implemented set.
// The instruction is executed in the cycle it is accepted: the register
// file is updated at that edge and the result beat is registered into the
// output buffer, and one request is taken every cycle while req_ready is high.
// The path that sets the rate is the single pass through the ALU and flag
// logic from the register file back into it.
// A two-entry output buffer keeps requests flowing while the receiver
// stalls; req_ready falls only once both entries hold beats.
// Reset clears A, X and Y, sets the stack pointer to FDh and the status to
// 24h, and empties the output buffer.
// ----------------------------------------------------------------------------
module cpu8_register_execute_unit_top
   import cpu8reu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_opcode,
   input  logic [7:0] req_operand,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_acc,
   output logic [7:0] rsp_index_x,
   output logic [7:0] rsp_index_y,
   output logic [7:0] rsp_stack_pointer,
   output logic [7:0] rsp_status,
   output logic       rsp_branch_taken,
   output logic       rsp_push_valid,
   output logic [7:0] rsp_push_data,
   output logic [8:0] rsp_stack_address,
   output logic       rsp_unsupported
);

   regs_type   regs_ff;
   regs_type   regs_in;
   result_type exec_result;
   result_type out_ff;
   result_type out_in;
   result_type skid_ff;
   result_type skid_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   logic       push;
   logic       pop;

   cpu8reu_exec u_exec (
      .cur_regs (regs_ff),
      .opcode   (req_opcode),
      .operand  (req_operand),
      .nxt_regs (regs_in),
      .result   (exec_result)
   );

   assign req_ready = ~skid_valid_ff;
   assign push      = req_valid & req_ready;
   assign pop       = out_valid_ff & rsp_ready;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = exec_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = exec_result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.a     <= RESET_ACC;
         regs_ff.x     <= RESET_INDEX;
         regs_ff.y     <= RESET_INDEX;
         regs_ff.s     <= RESET_SP;
         regs_ff.p     <= RESET_STATUS;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            regs_ff <= regs_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_acc           = out_ff.acc;
   assign rsp_index_x       = out_ff.index_x;
   assign rsp_index_y       = out_ff.index_y;
   assign rsp_stack_pointer = out_ff.stack_pointer;
   assign rsp_status        = out_ff.status;
   assign rsp_branch_taken  = out_ff.branch_taken;
   assign rsp_push_valid    = out_ff.push_valid;
   assign rsp_push_data     = out_ff.push_data;
   assign rsp_stack_address = out_ff.stack_address;
   assign rsp_unsupported   = out_ff.unsupported;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid entry held while output register is empty.");

   a_bit5_set: assert property (@(posedge clock) disable iff (reset)
      regs_ff.p[FLAG_5])
      else $error("Status bit 5 has been cleared.");

   a_push_decrements_sp: assert property (@(posedge clock) disable iff (reset)
      push && exec_result.push_valid |=> regs_ff.s == $past(regs_ff.s) - 8'd1)
      else $error("Stack pointer not decremented after a push.");

   a_unsupported_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unsupported |-> !rsp_push_valid && !rsp_branch_taken)
      else $error("Unsupported opcode produced a push or a branch.");

   a_stall_holds_regs: assert property (@(posedge clock) disable iff (reset)
      !push |=> $stable(regs_ff))
      else $error("Registers changed without an accepted beat.");

endmodule

// ----- rtl/cpu8reu_exec.sv -----
// ----------------------------------------------------------------------------
// cpu8reu_exec
// Single-pass instruction execution: takes the register file and one decoded
// instruction and produces the next register file and the result beat.
// ----------------------------------------------------------------------------
module cpu8reu_exec
   import cpu8reu_pkg::*;
(
   input  regs_type   cur_regs,
   input  logic [7:0] opcode,
   input  logic [7:0] operand,
   output regs_type   nxt_regs,
   output result_type result
);

   localparam logic [1:0] CC_ALU  = 2'b01;
   localparam logic [2:0] AAA_ORA = 3'd0;
   localparam logic [2:0] AAA_AND = 3'd1;
   localparam logic [2:0] AAA_EOR = 3'd2;
   localparam logic [2:0] AAA_STA = 3'd4;
   localparam logic [2:0] AAA_LDA = 3'd5;
   localparam logic [2:0] AAA_CMP = 3'd6;
   localparam logic [2:0] AAA_SBC = 3'd7;

   localparam logic [7:0] OP_LDX_IMM = 8'hA2, OP_LDX_ZP = 8'hA6, OP_LDX_ABS = 8'hAE;
   localparam logic [7:0] OP_LDX_ZPY = 8'hB6, OP_LDX_ABY = 8'hBE;
   localparam logic [7:0] OP_LDY_IMM = 8'hA0, OP_LDY_ZP = 8'hA4, OP_LDY_ABS = 8'hAC;
   localparam logic [7:0] OP_LDY_ZPX = 8'hB4, OP_LDY_ABX = 8'hBC;
   localparam logic [7:0] OP_CPY_IMM = 8'hC0, OP_CPY_ZP = 8'hC4, OP_CPY_ABS = 8'hCC;
   localparam logic [7:0] OP_CPX_IMM = 8'hE0, OP_CPX_ZP = 8'hE4, OP_CPX_ABS = 8'hEC;
   localparam logic [7:0] OP_BIT_ZP  = 8'h24, OP_BIT_ABS = 8'h2C;
   localparam logic [7:0] OP_ASL_A   = 8'h0A, OP_ROL_A   = 8'h2A;
   localparam logic [7:0] OP_LSR_A   = 8'h4A, OP_ROR_A   = 8'h6A;
   localparam logic [7:0] OP_TXA = 8'h8A, OP_TAX = 8'hAA, OP_DEX = 8'hCA, OP_NOP = 8'hEA;
   localparam logic [7:0] OP_TXS = 8'h9A, OP_TSX = 8'hBA, OP_DEY = 8'h88, OP_TAY = 8'hA8;
   localparam logic [7:0] OP_INY = 8'hC8, OP_INX = 8'hE8, OP_TYA = 8'h98;
   localparam logic [7:0] OP_CLC = 8'h18, OP_SEC = 8'h38, OP_CLI = 8'h58, OP_SEI = 8'h78;
   localparam logic [7:0] OP_CLV = 8'hB8, OP_CLD = 8'hD8, OP_SED = 8'hF8;
   localparam logic [7:0] OP_BPL = 8'h10, OP_BMI = 8'h30, OP_BVC = 8'h50, OP_BVS = 8'h70;
   localparam logic [7:0] OP_BCC = 8'h90, OP_BCS = 8'hB0, OP_BNE = 8'hD0, OP_BEQ = 8'hF0;
   localparam logic [7:0] OP_PHP = 8'h08, OP_PHA = 8'h48, OP_PLP = 8'h28, OP_PLA = 8'h68;

   logic [2:0] aaa;
   logic [7:0] addend;
   logic [8:0] sum;
   logic       sum_ovf;
   logic [7:0] sp_inc;
   logic [7:0] sp_dec;
   regs_type   work;
   logic       ok;
   logic       br;
   logic       pv;
   logic [7:0] pd;
   logic       stack_op;
   logic [8:0] saddr;

   assign aaa     = opcode[7:5];
   assign addend  = (aaa == AAA_SBC) ? ~operand : operand;
   assign sum     = {1'b0, cur_regs.a} + {1'b0, addend} + {8'h00, cur_regs.p[FLAG_C]};
   assign sum_ovf = ~(cur_regs.a[7] ^ addend[7]) & (cur_regs.a[7] ^ sum[7]);
   assign sp_inc  = cur_regs.s + 8'd1;
   assign sp_dec  = cur_regs.s - 8'd1;

   always_comb begin
      work     = cur_regs;
      ok       = 1'b1;
      br       = 1'b0;
      pv       = 1'b0;
      pd       = 8'h00;
      stack_op = 1'b0;
      saddr    = {1'b1, cur_regs.s};
      if ((opcode[1:0] == CC_ALU) && (aaa != AAA_STA)) begin
         case (aaa)
            AAA_ORA: begin
               work.a = cur_regs.a | operand;
               work.p = with_nz(cur_regs.p, work.a);
            end
            AAA_AND: begin
               work.a = cur_regs.a & operand;
               work.p = with_nz(cur_regs.p, work.a);
            end
            AAA_EOR: begin
               work.a = cur_regs.a ^ operand;
               work.p = with_nz(cur_regs.p, work.a);
            end
            AAA_LDA: begin
               work.a = operand;
               work.p = with_nz(cur_regs.p, work.a);
            end
            AAA_CMP: begin
               work.p = with_cmp(cur_regs.p, cur_regs.a, operand);
            end
            default: begin
               work.a         = sum[7:0];
               work.p         = with_nz(cur_regs.p, sum[7:0]);
               work.p[FLAG_C] = sum[8];
               work.p[FLAG_V] = sum_ovf;
            end
         endcase
      end else begin
         case (opcode)
            OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ABS, OP_LDX_ZPY, OP_LDX_ABY: begin
               work.x = operand;
               work.p = with_nz(cur_regs.p, operand);
            end
            OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS, OP_LDY_ZPX, OP_LDY_ABX: begin
               work.y = operand;
               work.p = with_nz(cur_regs.p, operand);
            end
            OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS: begin
               work.p = with_cmp(cur_regs.p, cur_regs.y, operand);
            end
            OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS: begin
               work.p = with_cmp(cur_regs.p, cur_regs.x, operand);
            end
            OP_BIT_ZP, OP_BIT_ABS: begin
               work.p[FLAG_N] = operand[7];
               work.p[FLAG_V] = operand[6];
               work.p[FLAG_Z] = ((cur_regs.a & operand) == 8'h00);
            end
            OP_ASL_A: begin
               work.a         = {cur_regs.a[6:0], 1'b0};
               work.p         = with_nz(cur_regs.p, work.a);
               work.p[FLAG_C] = cur_regs.a[7];
            end
            OP_ROL_A: begin
               work.a         = {cur_regs.a[6:0], cur_regs.p[FLAG_C]};
               work.p         = with_nz(cur_regs.p, work.a);
               work.p[FLAG_C] = cur_regs.a[7];
            end
            OP_LSR_A: begin
               work.a         = {1'b0, cur_regs.a[7:1]};
               work.p         = with_nz(cur_regs.p, work.a);
               work.p[FLAG_C] = cur_regs.a[0];
            end
            OP_ROR_A: begin
               work.a         = {cur_regs.p[FLAG_C], cur_regs.a[7:1]};
               work.p         = with_nz(cur_regs.p, work.a);
               work.p[FLAG_C] = cur_regs.a[0];
            end
            OP_TXA: begin
               work.a = cur_regs.x;
               work.p = with_nz(cur_regs.p, cur_regs.x);
            end
            OP_TAX: begin
               work.x = cur_regs.a;
               work.p = with_nz(cur_regs.p, cur_regs.a);
            end
            OP_DEX: begin
               work.x = cur_regs.x - 8'd1;
               work.p = with_nz(cur_regs.p, work.x);
            end
            OP_NOP: begin
               work = cur_regs;
            end
            OP_TXS: begin
               work.s = cur_regs.x;
            end
            OP_TSX: begin
               work.x = cur_regs.s;
               work.p = with_nz(cur_regs.p, cur_regs.s);
            end
            OP_DEY: begin
               work.y = cur_regs.y - 8'd1;
               work.p = with_nz(cur_regs.p, work.y);
            end
            OP_TAY: begin
               work.y = cur_regs.a;
               work.p = with_nz(cur_regs.p, cur_regs.a);
            end
            OP_INY: begin
               work.y = cur_regs.y + 8'd1;
               work.p = with_nz(cur_regs.p, work.y);
            end
            OP_INX: begin
               work.x = cur_regs.x + 8'd1;
               work.p = with_nz(cur_regs.p, work.x);
            end
            OP_TYA: begin
               work.a = cur_regs.y;
               work.p = with_nz(cur_regs.p, cur_regs.y);
            end
            OP_CLC: work.p[FLAG_C] = 1'b0;
            OP_SEC: work.p[FLAG_C] = 1'b1;
            OP_CLI: work.p[FLAG_I] = 1'b0;
            OP_SEI: work.p[FLAG_I] = 1'b1;
            OP_CLV: work.p[FLAG_V] = 1'b0;
            OP_CLD: work.p[FLAG_D] = 1'b0;
            OP_SED: work.p[FLAG_D] = 1'b1;
            OP_BPL: br = ~cur_regs.p[FLAG_N];
            OP_BMI: br = cur_regs.p[FLAG_N];
            OP_BVC: br = ~cur_regs.p[FLAG_V];
            OP_BVS: br = cur_regs.p[FLAG_V];
            OP_BCC: br = ~cur_regs.p[FLAG_C];
            OP_BCS: br = cur_regs.p[FLAG_C];
            OP_BNE: br = ~cur_regs.p[FLAG_Z];
            OP_BEQ: br = cur_regs.p[FLAG_Z];
            OP_PHP, OP_PHA: begin
               pv       = 1'b1;
               stack_op = 1'b1;
               if (opcode == OP_PHP) begin
                  pd         = cur_regs.p;
                  pd[FLAG_B] = 1'b1;
                  pd[FLAG_5] = 1'b1;
               end else begin
                  pd = cur_regs.a;
               end
               saddr  = {1'b1, cur_regs.s};
               work.s = sp_dec;
            end
            OP_PLP, OP_PLA: begin
               stack_op = 1'b1;
               work.s   = sp_inc;
               saddr    = {1'b1, sp_inc};
               if (opcode == OP_PLA) begin
                  work.a = operand;
                  work.p = with_nz(cur_regs.p, operand);
               end else begin
                  work.p         = operand;
                  work.p[FLAG_B] = cur_regs.p[FLAG_B];
                  work.p[FLAG_5] = cur_regs.p[FLAG_5];
               end
            end
            default: ok = 1'b0;
         endcase
      end

      if (!ok) begin
         work     = cur_regs;
         br       = 1'b0;
         pv       = 1'b0;
         pd       = 8'h00;
         stack_op = 1'b0;
      end
      if (!stack_op) begin
         saddr = {1'b1, work.s};
      end

      nxt_regs             = work;
      result.acc           = work.a;
      result.index_x       = work.x;
      result.index_y       = work.y;
      result.stack_pointer = work.s;
      result.status        = work.p;
      result.branch_taken  = br;
      result.push_valid    = pv;
      result.push_data     = pd;
      result.stack_address = saddr;
      result.unsupported   = ~ok;
   end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the 8-bit register execute unit.
// ----------------------------------------------------------------------------
// A shadow copy of A, X, Y, SP and P executes every accepted request beat
// and queues the register snapshot it expects. Each response beat is
// compared field by field with the oldest queued snapshot. A short directed
// run covers the reset state, flag edge cases, stack wrap, PHP/PLP, TSX,
// LDY abs,X and unknown opcodes. It is followed by bursts of random
// instructions, with random gaps from the sender and a changing stall
// pattern from the receiver.
// ----------------------------------------------------------------------------
module tb
   import cpu8reu_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      ALU_ORA, ALU_AND, ALU_EOR, ALU_ADC, ALU_STA, ALU_LDA, ALU_CMP, ALU_SBC
   } alu_op_type;

   typedef enum logic [7:0] {
      OP_BRK_UNUSED = 8'h02,
      OP_PHP = 8'h08, OP_ASL_A = 8'h0A, OP_BPL = 8'h10, OP_CLC = 8'h18,
      OP_BIT_ZP = 8'h24, OP_PLP = 8'h28, OP_ROL_A = 8'h2A, OP_BIT_ABS = 8'h2C,
      OP_BMI = 8'h30, OP_SEC = 8'h38, OP_PHA = 8'h48, OP_LSR_A = 8'h4A,
      OP_BVC = 8'h50, OP_CLI = 8'h58, OP_PLA = 8'h68, OP_ROR_A = 8'h6A,
      OP_BVS = 8'h70, OP_SEI = 8'h78, OP_DEY = 8'h88, OP_TXA = 8'h8A,
      OP_BCC = 8'h90, OP_TYA = 8'h98, OP_TXS = 8'h9A,
      OP_LDY_IMM = 8'hA0, OP_LDX_IMM = 8'hA2, OP_LDY_ZP = 8'hA4, OP_LDX_ZP = 8'hA6,
      OP_TAY = 8'hA8, OP_TAX = 8'hAA, OP_LDY_ABS = 8'hAC, OP_LDX_ABS = 8'hAE,
      OP_BCS = 8'hB0, OP_LDY_ZPX = 8'hB4, OP_LDX_ZPY = 8'hB6, OP_CLV = 8'hB8,
      OP_TSX = 8'hBA, OP_LDY_ABSX = 8'hBC, OP_LDX_ABSY = 8'hBE,
      OP_CPY_IMM = 8'hC0, OP_CPY_ZP = 8'hC4, OP_INY = 8'hC8, OP_DEX = 8'hCA,
      OP_CPY_ABS = 8'hCC, OP_BNE = 8'hD0, OP_CLD = 8'hD8,
      OP_CPX_IMM = 8'hE0, OP_CPX_ZP = 8'hE4, OP_INX = 8'hE8, OP_NOP = 8'hEA,
      OP_CPX_ABS = 8'hEC, OP_BEQ = 8'hF0, OP_SED = 8'hF8
   } opcode_type;

   typedef enum int unsigned {
      READY_ALWAYS, READY_RANDOM, READY_SHORT_STALL, READY_LONG_STALL
   } ready_mode_type;

   localparam logic [1:0] CC_ALU   = 2'b01;
   localparam logic [2:0] MODE_ZP  = 3'b001;
   localparam logic [2:0] MODE_IMM = 3'b010;
   localparam int unsigned RANDOM_BEATS = 1600;
   localparam int unsigned PRINT_CAP    = 40;

   class register_shadow_type;
      logic [7:0] acc_q, x_q, y_q, sp_q, p_q;
      result_type snapshots_due[$];
      int unsigned mismatch_count;
      int unsigned instructions_seen;
      int unsigned unsupported_seen;
      int unsigned beats_checked;

      function new();
         acc_q = RESET_ACC;
         x_q   = RESET_INDEX;
         y_q   = RESET_INDEX;
         sp_q  = RESET_SP;
         p_q   = RESET_STATUS;
      endfunction

      function logic [7:0] nz_of(logic [7:0] p, logic [7:0] v);
         logic [7:0] q;
         q = p;
         q[FLAG_N] = v[7];
         q[FLAG_Z] = (v == 8'h00);
         return q;
      endfunction

      function logic [7:0] compare_flags(logic [7:0] p, logic [7:0] r, logic [7:0] m);
         logic [7:0] q;
         q = nz_of(p, r - m);
         q[FLAG_C] = (r >= m);
         return q;
      endfunction

      function result_type execute_instruction(logic [7:0] op, logic [7:0] m);
         logic [7:0] a, x, y, s, p, v, pd;
         logic [8:0] sum, saddr;
         logic       ok, br, pv, stk, c0;
         result_type r;
         a = acc_q; x = x_q; y = y_q; s = sp_q; p = p_q;
         ok = 1'b1; br = 1'b0; pv = 1'b0; stk = 1'b0; pd = 8'h00; saddr = '0;
         if (op[1:0] == CC_ALU && op[7:5] != ALU_STA) begin
            case (op[7:5])
               ALU_ORA: begin a = a | m; p = nz_of(p, a); end
               ALU_AND: begin a = a & m; p = nz_of(p, a); end
               ALU_EOR: begin a = a ^ m; p = nz_of(p, a); end
               ALU_LDA: begin a = m; p = nz_of(p, a); end
               ALU_CMP: p = compare_flags(p, a, m);
               default: begin
                  v = (op[7:5] == ALU_SBC) ? ~m : m;
                  sum = {1'b0, a} + {1'b0, v} + {8'h00, p[FLAG_C]};
                  p[FLAG_C] = sum[8];
                  p[FLAG_V] = (a[7] == v[7]) && (sum[7] != a[7]);
                  a = sum[7:0];
                  p = nz_of(p, a);
               end
            endcase
         end else begin
            case (op)
               OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ABS, OP_LDX_ZPY, OP_LDX_ABSY: begin
                  x = m; p = nz_of(p, x);
               end
               OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS, OP_LDY_ZPX, OP_LDY_ABSX: begin
                  y = m; p = nz_of(p, y);
               end
               OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS: p = compare_flags(p, y, m);
               OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS: p = compare_flags(p, x, m);
               OP_BIT_ZP, OP_BIT_ABS: begin
                  p[FLAG_N] = m[7];
                  p[FLAG_V] = m[6];
                  p[FLAG_Z] = ((a & m) == 8'h00);
               end
               OP_ASL_A: begin p[FLAG_C] = a[7]; a = {a[6:0], 1'b0}; p = nz_of(p, a); end
               OP_ROL_A: begin
                  c0 = p[FLAG_C]; p[FLAG_C] = a[7]; a = {a[6:0], c0}; p = nz_of(p, a);
               end
               OP_LSR_A: begin p[FLAG_C] = a[0]; a = {1'b0, a[7:1]}; p = nz_of(p, a); end
               OP_ROR_A: begin
                  c0 = p[FLAG_C]; p[FLAG_C] = a[0]; a = {c0, a[7:1]}; p = nz_of(p, a);
               end
               OP_TXA: begin a = x; p = nz_of(p, a); end
               OP_TAX: begin x = a; p = nz_of(p, x); end
               OP_DEX: begin x = x - 8'd1; p = nz_of(p, x); end
               OP_NOP: ;
               OP_TXS: s = x;
               OP_TSX: begin x = s; p = nz_of(p, x); end
               OP_DEY: begin y = y - 8'd1; p = nz_of(p, y); end
               OP_TAY: begin y = a; p = nz_of(p, y); end
               OP_INY: begin y = y + 8'd1; p = nz_of(p, y); end
               OP_INX: begin x = x + 8'd1; p = nz_of(p, x); end
               OP_TYA: begin a = y; p = nz_of(p, a); end
               OP_CLC: p[FLAG_C] = 1'b0;
               OP_SEC: p[FLAG_C] = 1'b1;
               OP_CLI: p[FLAG_I] = 1'b0;
               OP_SEI: p[FLAG_I] = 1'b1;
               OP_CLV: p[FLAG_V] = 1'b0;
               OP_CLD: p[FLAG_D] = 1'b0;
               OP_SED: p[FLAG_D] = 1'b1;
               OP_BPL: br = !p[FLAG_N];
               OP_BMI: br = p[FLAG_N];
               OP_BVC: br = !p[FLAG_V];
               OP_BVS: br = p[FLAG_V];
               OP_BCC: br = !p[FLAG_C];
               OP_BCS: br = p[FLAG_C];
               OP_BNE: br = !p[FLAG_Z];
               OP_BEQ: br = p[FLAG_Z];
               OP_PHP, OP_PHA: begin
                  pv = 1'b1; stk = 1'b1;
                  pd = p;
                  pd[FLAG_B] = 1'b1;
                  pd[FLAG_5] = 1'b1;
                  if (op == OP_PHA) pd = a;
                  saddr = {1'b1, s};
                  s = s - 8'd1;
               end
               OP_PLP, OP_PLA: begin
                  stk = 1'b1;
                  s = s + 8'd1;
                  saddr = {1'b1, s};
                  if (op == OP_PLA) begin
                     a = m; p = nz_of(p, a);
                  end else begin
                     v = m;
                     v[FLAG_B] = p[FLAG_B];
                     v[FLAG_5] = p[FLAG_5];
                     p = v;
                  end
               end
               default: ok = 1'b0;
            endcase
         end
         if (ok) begin
            acc_q = a; x_q = x; y_q = y; sp_q = s; p_q = p;
         end else begin
            br = 1'b0; pv = 1'b0; pd = 8'h00; stk = 1'b0;
         end
         if (!stk) saddr = {1'b1, sp_q};
         r.acc           = acc_q;
         r.index_x       = x_q;
         r.index_y       = y_q;
         r.stack_pointer = sp_q;
         r.status        = p_q;
         r.branch_taken  = br;
         r.push_valid    = pv;
         r.push_data     = pd;
         r.stack_address = saddr;
         r.unsupported   = !ok;
         return r;
      endfunction

      function void note_instruction(logic [7:0] op, logic [7:0] m);
         result_type r;
         r = execute_instruction(op, m);
         if (r.unsupported) unsupported_seen++;
         instructions_seen++;
         snapshots_due.push_back(r);
      endfunction

      task report_mismatch(string what, int unsigned got, int unsigned want);
         if (mismatch_count < PRINT_CAP)
            $display("%0t: beat %0d %s: got %0h, expected %0h",
                     $time, beats_checked, what, got, want);
         mismatch_count++;
      endtask

      task check_beat(result_type got);
         result_type want;
         if (snapshots_due.size() == 0) begin
            report_mismatch("response with nothing outstanding", 0, 0);
         end else begin
            want = snapshots_due.pop_front();
            if (got.acc != want.acc) report_mismatch("acc", 32'(got.acc), 32'(want.acc));
            if (got.index_x != want.index_x)
               report_mismatch("index_x", 32'(got.index_x), 32'(want.index_x));
            if (got.index_y != want.index_y)
               report_mismatch("index_y", 32'(got.index_y), 32'(want.index_y));
            if (got.stack_pointer != want.stack_pointer)
               report_mismatch("stack_pointer", 32'(got.stack_pointer),
                               32'(want.stack_pointer));
            if (got.status != want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.branch_taken != want.branch_taken)
               report_mismatch("branch_taken", 32'(got.branch_taken),
                               32'(want.branch_taken));
            if (got.push_valid != want.push_valid)
               report_mismatch("push_valid", 32'(got.push_valid), 32'(want.push_valid));
            if (got.push_data != want.push_data)
               report_mismatch("push_data", 32'(got.push_data), 32'(want.push_data));
            if (got.stack_address != want.stack_address)
               report_mismatch("stack_address", 32'(got.stack_address),
                               32'(want.stack_address));
            if (got.unsupported != want.unsupported)
               report_mismatch("unsupported", 32'(got.unsupported),
                               32'(want.unsupported));
         end
         beats_checked++;
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_opcode = 8'h00;
   logic [7:0] req_operand = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_acc, rsp_index_x, rsp_index_y, rsp_stack_pointer, rsp_status;
   logic       rsp_branch_taken, rsp_push_valid, rsp_unsupported;
   logic [7:0] rsp_push_data;
   logic [8:0] rsp_stack_address;

   register_shadow_type shadow = new();
   logic [7:0]          opcode_list[$];
   ready_mode_type      ready_mode = READY_ALWAYS;
   int unsigned         ready_phase = 0;

   cpu8_register_execute_unit_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_operand       (req_operand),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_acc           (rsp_acc),
      .rsp_index_x       (rsp_index_x),
      .rsp_index_y       (rsp_index_y),
      .rsp_stack_pointer (rsp_stack_pointer),
      .rsp_status        (rsp_status),
      .rsp_branch_taken  (rsp_branch_taken),
      .rsp_push_valid    (rsp_push_valid),
      .rsp_push_data     (rsp_push_data),
      .rsp_stack_address (rsp_stack_address),
      .rsp_unsupported   (rsp_unsupported)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (req_valid && req_ready) shadow.note_instruction(req_opcode, req_operand);
         if (rsp_valid && rsp_ready) begin
            got.acc           = rsp_acc;
            got.index_x       = rsp_index_x;
            got.index_y       = rsp_index_y;
            got.stack_pointer = rsp_stack_pointer;
            got.status        = rsp_status;
            got.branch_taken  = rsp_branch_taken;
            got.push_valid    = rsp_push_valid;
            got.push_data     = rsp_push_data;
            got.stack_address = rsp_stack_address;
            got.unsupported   = rsp_unsupported;
            shadow.check_beat(got);
         end
      end
   end

   always @(negedge clock) begin
      if (ready_phase == 0) begin
         ready_mode  = ready_mode_type'($urandom_range(0, 3));
         ready_phase = $urandom_range(20, 120);
      end
      ready_phase--;
      case (ready_mode)
         READY_ALWAYS:      rsp_ready <= 1'b1;
         READY_RANDOM:      rsp_ready <= 1'($urandom_range(0, 1));
         READY_SHORT_STALL: rsp_ready <= (ready_phase % 3) != 0;
         READY_LONG_STALL:  rsp_ready <= (ready_phase % 8) < 2;
         default:           rsp_ready <= 1'b1;
      endcase
   end

   task automatic drive_beat(logic [7:0] op, logic [7:0] m);
      req_valid   = 1'b1;
      req_opcode  = op;
      req_operand = m;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic idle_cycles(int unsigned n);
      req_valid = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (shadow.snapshots_due.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_opcode();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return 8'($urandom_range(0, 255));
      if (roll < 55) return {3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), CC_ALU};
      return opcode_list[$urandom_range(0, opcode_list.size() - 1)];
   endfunction

   function automatic logic [7:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      opcode_type  op_iter;
      int unsigned issued;
      int unsigned burst;
      bit          drained_mid;
      op_iter = op_iter.first();
      do begin
         opcode_list.push_back(op_iter);
         op_iter = op_iter.next();
      end while (op_iter != op_iter.first());

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      drive_beat(OP_NOP, pick_operand());
      drive_beat(OP_BPL, pick_operand());
      drive_beat({ALU_LDA, MODE_IMM, CC_ALU}, 8'h80);
      drive_beat(OP_BMI, pick_operand());
      drive_beat({ALU_ADC, MODE_IMM, CC_ALU}, 8'h80);
      drive_beat(OP_BVS, pick_operand());
      drive_beat(OP_BEQ, pick_operand());
      drive_beat({ALU_SBC, MODE_IMM, CC_ALU}, 8'h01);
      drive_beat({ALU_CMP, MODE_ZP, CC_ALU}, 8'hFF);
      drive_beat(OP_LDX_IMM, 8'h00);
      drive_beat(OP_TXS, pick_operand());
      drive_beat(OP_PHA, pick_operand());
      drive_beat(OP_PLA, 8'h00);
      drive_beat(OP_PHP, pick_operand());
      drive_beat(OP_PLP, 8'hFF);
      drive_beat(OP_PLP, 8'h00);
      drive_beat(OP_TSX, pick_operand());
      drive_beat(OP_LDY_ABSX, 8'h80);
      drive_beat(OP_BIT_ZP, 8'hC0);
      drive_beat(OP_ROR_A, pick_operand());
      drive_beat(OP_ASL_A, pick_operand());
      drive_beat(OP_LSR_A, pick_operand());
      drive_beat(OP_SED, pick_operand());
      drive_beat(OP_BRK_UNUSED, 8'hFF);
      drive_beat({ALU_STA, MODE_IMM, CC_ALU}, 8'h00);
      wait_for_drain();

      issued      = 0;
      drained_mid = 1'b0;
      while (issued < RANDOM_BEATS) begin
         burst = $urandom_range(1, 48);
         repeat (burst) begin
            drive_beat(pick_opcode(), pick_operand());
            issued++;
         end
         if (issued >= RANDOM_BEATS / 2 && !drained_mid) begin
            wait_for_drain();
            drained_mid = 1'b1;
         end
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
      end
      req_valid = 1'b0;

      while (shadow.snapshots_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Executed %0d instructions (%0d unsupported opcodes), %0d response beats checked.",
               shadow.instructions_seen, shadow.unsupported_seen, shadow.beats_checked);
      $display("Random bursts ran with sender gaps, receiver stalls and one full drain.");
      if (shadow.mismatch_count == 0 && shadow.snapshots_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d responses outstanding.", shadow.snapshots_due.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
